// ===== rtl/core/ped_pkg.sv =====
`timescale 1ns / 1ps

package ped_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [7:0] PCT_SIGN = 8'h25;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_item;

    // Up to three literal or decoded bytes; last applies to the final one.
    typedef struct packed {
        logic [1:0]      n;
        logic [2:0][7:0] bytes;
        logic            last;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PCT   = 3'b010,
        PH_DIGIT = 3'b100
    } t_phase;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
                 (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
        end else begin
            d = c - 8'h37;
        end
        hex_nibble = d[3:0];
    endfunction

endpackage

// ===== rtl/core/ped_front.sv =====
`timescale 1ns / 1ps

module ped_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  ped_pkg::t_in_item     i_in,
    output logic                  o_in_stall,
    input  ped_pkg::t_queue_status i_status,
    output logic                  o_push,
    output ped_pkg::t_cmd         o_cmd
);
    import ped_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic       accept;
    logic [7:0] b;
    logic       last;
    t_cmd       cmd;

    assign o_in_stall = i_status.full;
    assign accept     = i_in_valid && !i_status.full;
    assign b          = i_in.in_byte;
    assign last       = i_in.in_last;

    always_comb begin
        n_phase   = r_phase;
        n_held    = r_held;
        cmd.n     = 2'd0;
        cmd.bytes = '0;
        cmd.last  = last;
        unique case (r_phase)
            PH_PCT: begin
                if (is_hex(b)) begin
                    if (last) begin
                        cmd.n        = 2'd2;
                        cmd.bytes[0] = PCT_SIGN;
                        cmd.bytes[1] = b;
                        n_phase      = PH_IDLE;
                    end else begin
                        n_held  = b;
                        n_phase = PH_DIGIT;
                    end
                end else begin
                    cmd.bytes[0] = PCT_SIGN;
                    if (b == PCT_SIGN && !last) begin
                        cmd.n   = 2'd1;
                        n_phase = PH_PCT;
                    end else begin
                        cmd.n        = 2'd2;
                        cmd.bytes[1] = b;
                        n_phase      = PH_IDLE;
                    end
                end
            end
            PH_DIGIT: begin
                if (is_hex(b)) begin
                    cmd.n        = 2'd1;
                    cmd.bytes[0] = {hex_nibble(r_held), hex_nibble(b)};
                    n_phase      = PH_IDLE;
                end else begin
                    cmd.bytes[0] = PCT_SIGN;
                    cmd.bytes[1] = r_held;
                    if (b == PCT_SIGN && !last) begin
                        cmd.n   = 2'd2;
                        n_phase = PH_PCT;
                    end else begin
                        cmd.n        = 2'd3;
                        cmd.bytes[2] = b;
                        n_phase      = PH_IDLE;
                    end
                end
            end
            default: begin
                if (b == PCT_SIGN && !last) begin
                    n_phase = PH_PCT;
                end else begin
                    cmd.n        = 2'd1;
                    cmd.bytes[0] = b;
                    n_phase      = PH_IDLE;
                end
            end
        endcase
        if (last) begin
            n_phase = PH_IDLE;
            n_held  = 8'h00;
        end
    end

    assign o_push = accept && (cmd.n != 2'd0);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= 8'h00;
        end else if (accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

`ifndef SYNTHESIS
    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> accept)
        else $error("push without transfer");
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last) |-> o_push)
        else $error("final byte produced no result");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last) |=> (r_phase == PH_IDLE && r_held == 8'h00))
        else $error("state not cleared after final byte");
    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_phase == PH_IDLE && b != PCT_SIGN) |-> (o_push && cmd.n == 2'd1))
        else $error("plain byte not passed through");
`endif

endmodule

// ===== rtl/core/ped_queue.sv =====
`timescale 1ns / 1ps

module ped_queue #(
    parameter int unsigned DEPTH = ped_pkg::QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  ped_pkg::t_cmd          i_cmd,
    input  logic                   i_pop,
    output ped_pkg::t_cmd          o_head,
    output ped_pkg::t_queue_status o_status
);
    import ped_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wp, n_wp;
    logic [AW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_status.full  = (r_cnt == CW'(DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count out of range");
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/core/ped_back.sv =====
`timescale 1ns / 1ps

module ped_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ped_pkg::t_cmd          i_head,
    input  ped_pkg::t_queue_status i_status,
    output logic                   o_pop,
    output logic                   o_out_valid,
    output ped_pkg::t_out_item     o_out,
    input  logic                   i_out_stall
);
    import ped_pkg::*;

    t_cmd       r_cmd;
    logic [1:0] r_idx;
    logic       r_busy;
    logic       r_ov;
    t_out_item  r_out;
    logic       slot_free;
    logic       cur_final;
    logic       head_final;

    assign slot_free   = !r_ov || !i_out_stall;
    assign cur_final   = (r_idx == r_cmd.n - 2'd1);
    assign head_final  = (i_head.n == 2'd1);
    assign o_pop       = slot_free && !r_busy && !i_status.empty;
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
            r_idx  <= 2'd0;
        end else if (slot_free) begin
            if (r_busy) begin
                r_ov <= 1'b1;
                if (cur_final) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end else if (!i_status.empty) begin
                r_ov <= 1'b1;
                if (!head_final) begin
                    r_busy <= 1'b1;
                    r_idx  <= 2'd1;
                end
            end else begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free) begin
            if (r_busy) begin
                r_out.out_byte <= r_cmd.bytes[r_idx];
                r_out.out_last <= cur_final && r_cmd.last;
            end else if (!i_status.empty) begin
                r_out.out_byte <= i_head.bytes[0];
                r_out.out_last <= head_final && i_head.last;
                r_cmd          <= i_head;
            end
        end
    end

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx != 2'd0 && r_idx < r_cmd.n))
        else $error("byte index out of range");
    a_busy_fed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> r_ov)
        else $error("record started without a result");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_pop)
        else $error("pop while record in progress");
`endif

endmodule

// ===== rtl/core/percent_escape_decoder.sv =====
`timescale 1ns / 1ps

// Streaming URL percent decoder. One raw URI byte is taken per cycle unless
// the input is stalled; decoded bytes leave at one per cycle through a
// registered output while it is not stalled. A '%' and its first hex digit
// are held in the front stage until the escape resolves; a malformed or
// cut-off escape produces up to three bytes for one input, which a command
// queue of QDEPTH entries absorbs while the output drains them one per cycle.
// Input is stalled only when that queue is full, so the sustained rate is one
// byte per cycle whenever each input yields at most one output and the output
// is not stalled. A result is registered in the queue, then in the output.
module percent_escape_decoder #(
    parameter int unsigned QDEPTH = ped_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  ped_pkg::t_in_item  i_in,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output ped_pkg::t_out_item o_out,
    input  logic               i_out_stall
);
    import ped_pkg::*;

    logic          push;
    logic          pop;
    t_cmd          cmd;
    t_cmd          head;
    t_queue_status status;

    ped_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_push     (push),
        .o_cmd      (cmd)
    );

    ped_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (cmd),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (status)
    );

    ped_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_status    (status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== bench/tb_percent_escape_decoder.sv =====
`timescale 1ns / 1ps

module tb_percent_escape_decoder;
    import ped_pkg::*;

    localparam int unsigned RANDOM_CHARS = 405;
    localparam int unsigned PHASE_CHARS  = 60;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
        logic       typed;
        logic [7:0] want_byte;
        logic       want_last;
    } t_script_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    t_in_item  i_in;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out;
    logic      i_out_stall;

    t_out_item   want_chars[$];
    t_phase      esc_phase;
    logic [7:0]  esc_digit;
    logic        row_typed;
    t_out_item   row_want;
    bit          tx_idle;
    bit          rx_idle;
    bit          hold_req;
    int unsigned errors;
    int unsigned quiet_cycles;

    t_script_row script [25] = '{
        '{"A",      1'b0, 1'b1, "A",      1'b0},
        '{8'h00,    1'b0, 1'b1, 8'h00,    1'b0},
        '{8'hFF,    1'b0, 1'b1, 8'hFF,    1'b0},
        '{PCT_SIGN, 1'b0, 1'b0, 8'h00,    1'b0},
        '{"4",      1'b0, 1'b0, 8'h00,    1'b0},
        '{"1",      1'b0, 1'b1, "A",      1'b0},
        '{PCT_SIGN, 1'b0, 1'b0, 8'h00,    1'b0},
        '{"f",      1'b0, 1'b0, 8'h00,    1'b0},
        '{"F",      1'b0, 1'b1, 8'hFF,    1'b0},
        '{PCT_SIGN, 1'b0, 1'b0, 8'h00,    1'b0},
        '{"0",      1'b0, 1'b0, 8'h00,    1'b0},
        '{"0",      1'b0, 1'b1, 8'h00,    1'b0},
        '{PCT_SIGN, 1'b0, 1'b0, 8'h00,    1'b0},
        '{"G",      1'b0, 1'b0, 8'h00,    1'b0},
        '{PCT_SIGN, 1'b0, 1'b0, 8'h00,    1'b0},
        '{"a",      1'b0, 1'b0, 8'h00,    1'b0},
        '{PCT_SIGN, 1'b0, 1'b0, 8'h00,    1'b0},
        '{"2",      1'b0, 1'b0, 8'h00,    1'b0},
        '{"5",      1'b1, 1'b1, PCT_SIGN, 1'b1},
        '{PCT_SIGN, 1'b0, 1'b0, 8'h00,    1'b0},
        '{"9",      1'b1, 1'b0, 8'h00,    1'b0},
        '{PCT_SIGN, 1'b0, 1'b0, 8'h00,    1'b0},
        '{"b",      1'b0, 1'b0, 8'h00,    1'b0},
        '{PCT_SIGN, 1'b1, 1'b0, 8'h00,    1'b0},
        '{PCT_SIGN, 1'b1, 1'b1, PCT_SIGN, 1'b1}
    };

    percent_escape_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // bit 4 flags a hex digit, bits 3:0 hold its value
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c inside {[8'h30:8'h39]}) begin
            return {1'b1, c[3:0]};
        end
        if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            return {1'b1, c[3:0] + 4'd9};
        end
        return 5'd0;
    endfunction

    function automatic logic [7:0] hex_char();
        int unsigned v;
        v = $urandom_range(0, 21);
        if (v < 10) begin
            return 8'h30 + v[7:0];
        end else if (v < 16) begin
            return 8'h61 + v[7:0] - 8'd10;
        end
        return 8'h41 + v[7:0] - 8'd16;
    endfunction

    function automatic logic [7:0] other_char();
        logic [7:0] c;
        logic [4:0] v;
        if ($urandom_range(0, 4) == 0) begin
            return PCT_SIGN;
        end
        do begin
            c = 8'($urandom_range(0, 255));
            v = nibble_of(c);
        end while (v[4]);
        return c;
    endfunction

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic void emit(input logic [7:0] b, input logic last);
        t_out_item o;
        o.out_byte = b;
        o.out_last = last;
        want_chars.push_back(o);
    endfunction

    function automatic void scan_plain(input logic [7:0] b, input logic last);
        if (b == PCT_SIGN && !last) begin
            esc_phase = PH_PCT;
        end else begin
            emit(b, last);
            esc_phase = PH_IDLE;
        end
    endfunction

    function automatic void decode_char(input t_in_item it);
        logic [4:0] cur;
        logic [4:0] first;
        cur = nibble_of(it.in_byte);
        case (esc_phase)
            PH_PCT: begin
                if (cur[4]) begin
                    if (it.in_last) begin
                        emit(PCT_SIGN, 1'b0);
                        emit(it.in_byte, 1'b1);
                        esc_phase = PH_IDLE;
                    end else begin
                        esc_digit = it.in_byte;
                        esc_phase = PH_DIGIT;
                    end
                end else begin
                    emit(PCT_SIGN, 1'b0);
                    scan_plain(it.in_byte, it.in_last);
                end
            end
            PH_DIGIT: begin
                if (cur[4]) begin
                    first = nibble_of(esc_digit);
                    emit({first[3:0], cur[3:0]}, it.in_last);
                    esc_phase = PH_IDLE;
                end else begin
                    emit(PCT_SIGN, 1'b0);
                    emit(esc_digit, 1'b0);
                    scan_plain(it.in_byte, it.in_last);
                end
            end
            default: begin
                scan_plain(it.in_byte, it.in_last);
            end
        endcase
        if (it.in_last) begin
            esc_phase = PH_IDLE;
            esc_digit = 8'h00;
        end
    endfunction

    always @(posedge i_clk) begin
        int unsigned n0;
        t_out_item want;
        if (!i_rst_n) begin
            esc_phase = PH_IDLE;
            esc_digit = 8'h00;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (want_chars.size() == 0) begin
                    $error("unexpected out_byte %02h out_last %0b", o_out.out_byte,
                           o_out.out_last);
                    errors++;
                end else begin
                    want = want_chars.pop_front();
                    if (o_out.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %02h, got %02h", want.out_byte,
                               o_out.out_byte);
                        errors++;
                    end
                    if (o_out.out_last !== want.out_last) begin
                        $error("out_last: expected %0b, got %0b", want.out_last,
                               o_out.out_last);
                        errors++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                n0 = want_chars.size();
                decode_char(i_in);
                if (row_typed) begin
                    while (want_chars.size() > n0) begin
                        void'(want_chars.pop_back());
                    end
                    want_chars.push_back(row_want);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("** percent_escape_decoder: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        int unsigned gap;
        forever begin
            if (hold_req) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                gap = rx_idle ? idle_len() : 0;
                i_out_stall = (gap != 0);
                repeat ((gap == 0) ? 1 : gap) @(negedge i_clk);
            end
        end
    end

    task automatic push_char(input t_in_item it, input logic typed, input t_out_item want);
        int unsigned gap;
        gap = tx_idle ? idle_len() : 0;
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in       = it;
        row_typed  = typed;
        row_want   = want;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic send_uris(input int unsigned budget, inout int unsigned sent);
        logic [7:0]  text[$];
        int unsigned goal;
        int unsigned tokens;
        int unsigned r;
        t_in_item    it;
        goal = sent + budget;
        while (sent < goal) begin
            text.delete();
            tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(2, 10);
            repeat (tokens) begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    text.push_back(PCT_SIGN);
                    text.push_back(hex_char());
                    text.push_back(hex_char());
                end else if (r < 65) begin
                    text.push_back(8'($urandom_range(8'h20, 8'h7e)));
                end else if (r < 78) begin
                    text.push_back(8'($urandom_range(0, 255)));
                end else if (r < 86) begin
                    text.push_back(PCT_SIGN);
                    text.push_back(other_char());
                end else if (r < 93) begin
                    text.push_back(PCT_SIGN);
                    text.push_back(hex_char());
                    text.push_back(other_char());
                end else begin
                    text.push_back(PCT_SIGN);
                end
            end
            foreach (text[k]) begin
                it.in_byte = text[k];
                it.in_last = (k == text.size() - 1);
                push_char(it, 1'b0, '0);
                sent++;
            end
        end
    endtask

    initial begin
        int unsigned sent;
        int unsigned ph;
        t_in_item    it;
        t_out_item   want;
        tx_idle      = 1'b0;
        rx_idle      = 1'b0;
        row_typed    = 1'b0;
        row_want     = '0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in         = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (script[k]) begin
            it.in_byte    = script[k].in_byte;
            it.in_last    = script[k].in_last;
            want.out_byte = script[k].want_byte;
            want.out_last = script[k].want_last;
            push_char(it, script[k].typed, want);
        end

        sent = 0;
        ph   = 0;
        while (sent < RANDOM_CHARS) begin
            tx_idle = (ph % 4 == 1) || (ph % 4 == 3);
            rx_idle = (ph % 4 == 1) || (ph % 4 == 2);
            if (ph == 2 || ph == 5) begin
                tx_idle  = 1'b0;
                hold_req = 1'b1;
            end
            send_uris(PHASE_CHARS, sent);
            ph++;
        end
        i_in_valid = 1'b0;

        while (want_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("** percent_escape_decoder: PASSED **");
        end else begin
            $display("** percent_escape_decoder: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ped_pkg.sv
rtl/core/ped_front.sv
rtl/core/ped_queue.sv
rtl/core/ped_back.sv
rtl/core/percent_escape_decoder.sv
bench/tb_percent_escape_decoder.sv
